// ===== src/hl_acc_pkg.sv =====
package hl_acc_pkg;

    // Block sizing
    localparam int NUM_ANGLES  = 180;
    localparam int RHO_MAX     = 724;
    localparam int IMAGE_SIZE  = 512;
    localparam int COUNT_WIDTH = 18;

    localparam int RHO_CELLS  = 2 * RHO_MAX + 1;
    localparam int ACC_DEPTH  = RHO_CELLS * NUM_ANGLES;
    localparam int ADDR_W     = $clog2(ACC_DEPTH);
    localparam int ANG_W      = (NUM_ANGLES > 2) ? $clog2(NUM_ANGLES) : 1;
    localparam int RHO_CELL_W = $clog2(RHO_CELLS);

    // Fixed field widths of the stream payloads
    localparam int ROW_W        = 9;
    localparam int RD_RHO_W     = 11;
    localparam int RD_ANG_W     = 8;
    localparam int THRESH_W     = 18;
    localparam int VOTE_COUNT_W = 18;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 24;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);

    // Fixed-point datapath
    localparam int TRIG_W     = 16;
    localparam int FRAC_W     = 15;
    localparam int TRUNC_BIAS = 2 ** FRAC_W - 1;
    localparam int PROD_W     = ROW_W + 1 + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int QUOT_W     = SUM_W - FRAC_W;
    localparam int IDX_W      = ((QUOT_W > RHO_CELL_W + 1) ? QUOT_W : RHO_CELL_W + 1) + 1;

    // Angle table generation (elaboration only)
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int TAYLOR_TERMS = 10;

    // Command codes carried on s_tuser
    localparam logic CMD_VOTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_VOTE   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_READ   = 6'b010000,
        ST_RESULT = 6'b100000
    } hl_state_t;

    // Input beat layout, lowest field last
    typedef struct packed {
        logic [S_TDATA_W-ROW_W*2-1-RD_RHO_W-RD_ANG_W-1:0] pad;
        logic [RD_ANG_W-1:0] read_angle_index;
        logic [RD_RHO_W-1:0] read_rho_index;
        logic                pixel_is_black;
        logic [ROW_W-1:0]    pixel_col;
        logic [ROW_W-1:0]    pixel_row;
    } hl_in_data_t;

    // Output beat layout
    typedef struct packed {
        logic [M_TDATA_W-VOTE_COUNT_W-2:0] pad;
        logic                    above_threshold;
        logic [VOTE_COUNT_W-1:0] vote_count;
    } hl_out_data_t;

    // Sequencer to rho unit: one angle step
    typedef struct packed {
        logic             valid;
        logic [ANG_W-1:0] angle;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } hl_issue_t;

    // Rho unit result: an in-range cell to bump
    typedef struct packed {
        logic                  valid;
        logic [RHO_CELL_W-1:0] idx;
        logic [ANG_W-1:0]      angle;
    } hl_rho_t;

    function automatic longint hl_q30_to_q15(input longint v);
        longint r;
        r = (v < 0) ? 64'sd0 : v;
        r = (r + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return r;
    endfunction

    // Unsigned restoring long division, truncating, for table generation
    function automatic longint unsigned hl_udiv64(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            q = {q[62:0], 1'b0};
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // {cos, sin} in Q1.15 for angle step k, Taylor series in Q30
    function automatic logic [2*TRIG_W-1:0] hl_trig_q15(input int unsigned k);
        logic upper;
        longint unsigned m;
        longint unsigned a;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint unsigned div_s;
        longint unsigned div_c;
        longint ss;
        longint cs;
        longint cq;
        longint sq;
        upper = (2 * k) > NUM_ANGLES;
        m = upper ? longint'(NUM_ANGLES - k) : longint'(k);
        a = hl_udiv64(m * PI_Q30, 64'(NUM_ANGLES));
        x2 = (a * a) >> 30;
        ts = a;
        tc = 64'd1 << 30;
        ss = longint'(a);
        cs = longint'(tc);
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            div_s = longint'((2 * n) * (2 * n + 1));
            div_c = longint'((2 * n - 1) * (2 * n));
            ts = hl_udiv64((ts * x2) >> 30, div_s);
            tc = hl_udiv64((tc * x2) >> 30, div_c);
            if (n[0] == 1'b1) begin
                ss = ss - longint'(ts);
                cs = cs - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                cs = cs + longint'(tc);
            end
        end
        cq = hl_q30_to_q15(cs);
        if (upper) begin
            cq = -cq;
        end
        sq = hl_q30_to_q15(ss);
        return {TRIG_W'(cq), TRIG_W'(sq)};
    endfunction

endpackage

// ===== src/hl_acc_ram.sv =====
module hl_acc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/hl_acc_trig_rom.sv =====
module hl_acc_trig_rom import hl_acc_pkg::*; (
    input  logic [ANG_W-1:0]         angle,
    output logic signed [TRIG_W-1:0] cos_q15,
    output logic signed [TRIG_W-1:0] sin_q15
);

    logic signed [TRIG_W-1:0] cos_tab [NUM_ANGLES];
    logic signed [TRIG_W-1:0] sin_tab [NUM_ANGLES];

    // Constant table, folded at elaboration
    for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_tab
        localparam logic [2*TRIG_W-1:0] Entry = hl_trig_q15(g);
        assign cos_tab[g] = Entry[2*TRIG_W-1:TRIG_W];
        assign sin_tab[g] = Entry[TRIG_W-1:0];
    end

    // angle is always below NUM_ANGLES
    assign cos_q15 = cos_tab[angle];
    assign sin_q15 = sin_tab[angle];

endmodule

// ===== src/hl_acc_rho_unit.sv =====
module hl_acc_rho_unit import hl_acc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  hl_issue_t issue,
    output hl_rho_t   rho,
    output logic      busy
);

    logic signed [TRIG_W-1:0] cos_w;
    logic signed [TRIG_W-1:0] sin_w;

    // Stage T: table lookup
    logic                     t_valid_reg;
    logic [ANG_W-1:0]         t_angle_reg;
    logic signed [TRIG_W-1:0] t_cos_reg;
    logic signed [TRIG_W-1:0] t_sin_reg;
    logic [ROW_W-1:0]         t_row_reg;
    logic [ROW_W-1:0]         t_col_reg;

    // Stage A: products
    logic                     a_valid_reg;
    logic [ANG_W-1:0]         a_angle_reg;
    logic signed [PROD_W-1:0] a_prow_reg;
    logic signed [PROD_W-1:0] a_pcol_reg;
    logic signed [PROD_W-1:0] a_prow_next;
    logic signed [PROD_W-1:0] a_pcol_next;
    logic signed [ROW_W:0]    row_s;
    logic signed [ROW_W:0]    col_s;

    // Stage B: rho cell index
    logic                  b_valid_reg;
    logic [RHO_CELL_W-1:0] b_idx_reg;
    logic [ANG_W-1:0]      b_angle_reg;
    logic                  b_valid_next;

    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        bias;
    logic signed [SUM_W-1:0] quot;
    logic signed [IDX_W-1:0] idx;

    hl_acc_trig_rom u_trig (
        .angle   (issue.angle),
        .cos_q15 (cos_w),
        .sin_q15 (sin_w)
    );

    // row*cos and col*sin, both Q15
    assign row_s       = $signed({1'b0, t_row_reg});
    assign col_s       = $signed({1'b0, t_col_reg});
    assign a_prow_next = row_s * t_cos_reg;
    assign a_pcol_next = col_s * t_sin_reg;

    // Sum, truncate toward zero, offset by RHO_MAX, range check
    assign sum  = SUM_W'(a_prow_reg) + SUM_W'(a_pcol_reg);
    assign bias = sum[SUM_W-1] ? SUM_W'(TRUNC_BIAS) : '0;
    assign quot = (sum + $signed(bias)) >>> FRAC_W;
    assign idx  = IDX_W'(quot) + IDX_W'(RHO_MAX);
    assign b_valid_next = a_valid_reg && (idx >= 0) && (idx <= $signed(IDX_W'(2 * RHO_MAX)));

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            t_valid_reg <= issue.valid;
            a_valid_reg <= t_valid_reg;
            b_valid_reg <= b_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        t_angle_reg <= issue.angle;
        t_cos_reg   <= cos_w;
        t_sin_reg   <= sin_w;
        t_row_reg   <= issue.row;
        t_col_reg   <= issue.col;
        a_angle_reg <= t_angle_reg;
        a_prow_reg  <= a_prow_next;
        a_pcol_reg  <= a_pcol_next;
        b_idx_reg   <= RHO_CELL_W'(idx);
        b_angle_reg <= a_angle_reg;
    end

    assign rho.valid = b_valid_reg;
    assign rho.idx   = b_idx_reg;
    assign rho.angle = b_angle_reg;
    assign busy      = t_valid_reg | a_valid_reg | b_valid_reg;

endmodule

// ===== src/hough_line_vote_accumulator_top.sv =====
// Hough line vote accumulator. A beat on the s_ side with tuser = 0 brings a pixel; a
// black pixel inside the image casts one vote in each of NUM_ANGLES angle columns of a
// (2*RHO_MAX+1) x NUM_ANGLES array of saturating counters, and produces no output beat.
// A beat with tuser = 1 reads one counter and returns one m_ beat with the count and a
// flag that is set when the count is above the threshold register. A black pixel occupies
// the block through the VOTE and DRAIN states, one angle step per cycle through the
// shared rho unit into the read-modify-write port pair of the counter RAM; a white pixel
// or a pixel outside the image is taken while the block stays idle; a read passes through
// the READ and RESULT states, waiting in RESULT for the output register. After reset a
// clearing pass writes zero to all ACC_DEPTH counters (260820 at the default sizes), one
// per cycle, during which s_tready stays low; the threshold can be written at any time the
// block is idle, including during the clearing pass.
module hough_line_vote_accumulator_top import hl_acc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: pixel_row[8:0], pixel_col[17:9], pixel_is_black[18],
    //          read_rho_index[29:19], read_angle_index[37:30], zero pad
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd (0 = vote, 1 = read)
    input  logic                 s_tuser,
    // m_tdata: vote_count[17:0], above_threshold[18], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [THRESH_W-1:0]  cfg_data
);

    hl_state_t state_reg, state_next;

    hl_in_data_t  in_d;
    hl_out_data_t out_d;

    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [ANG_W-1:0]       angle_step_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       col_reg;
    logic [RHO_CELL_W-1:0]  rd_rho_reg;
    logic [ANG_W-1:0]       rd_ang_reg;
    logic                   rd_ok_reg;
    logic                   c_valid_reg;
    logic [ADDR_W-1:0]      c_addr_reg;
    logic [THRESH_W-1:0]    thr_reg;
    logic                   m_tvalid_reg;
    logic [VOTE_COUNT_W-1:0] m_count_reg;
    logic                   m_above_reg;

    logic in_beat;
    logic vote_go;
    logic read_ok;
    logic out_free;
    logic last_step;

    hl_issue_t issue;
    hl_rho_t   rho;
    logic      rho_busy;

    logic [RHO_CELL_W-1:0]  addr_idx;
    logic [ANG_W-1:0]       addr_ang;
    logic [ADDR_W-1:0]      cell_addr;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] bumped;
    logic [COUNT_WIDTH-1:0] rd_count;

    assign in_d      = s_tdata;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid & s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_step = (angle_step_reg == ANG_W'(NUM_ANGLES - 1));

    assign vote_go = in_d.pixel_is_black
                  && (32'(in_d.pixel_row) < IMAGE_SIZE)
                  && (32'(in_d.pixel_col) < IMAGE_SIZE);
    assign read_ok = (32'(in_d.read_rho_index) < RHO_CELLS)
                  && (32'(in_d.read_angle_index) < NUM_ANGLES);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(ACC_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_tuser == CMD_READ) begin
                        state_next = ST_READ;
                    end else if (vote_go) begin
                        state_next = ST_VOTE;
                    end
                end
            end
            ST_VOTE: begin
                if (last_step) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rho_busy && !c_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            angle_step_reg <= '0;
            c_valid_reg    <= 1'b0;
            thr_reg        <= THRESH_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            c_valid_reg <= rho.valid;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == ST_VOTE) begin
                angle_step_reg <= last_step ? '0 : angle_step_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (state_reg == ST_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item and result payloads
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            row_reg    <= in_d.pixel_row;
            col_reg    <= in_d.pixel_col;
            rd_rho_reg <= RHO_CELL_W'(in_d.read_rho_index);
            rd_ang_reg <= ANG_W'(in_d.read_angle_index);
            rd_ok_reg  <= read_ok;
        end
        c_addr_reg <= cell_addr;
        if (state_reg == ST_RESULT && out_free) begin
            m_count_reg <= VOTE_COUNT_W'(rd_count);
            m_above_reg <= (32'(rd_count) > 32'(thr_reg));
        end
    end

    // One angle step per cycle into the rho unit
    assign issue.valid = (state_reg == ST_VOTE);
    assign issue.angle = angle_step_reg;
    assign issue.row   = row_reg;
    assign issue.col   = col_reg;

    hl_acc_rho_unit u_rho (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .rho     (rho),
        .busy    (rho_busy)
    );

    // Cell address: rho index times NUM_ANGLES plus angle
    assign addr_idx  = (state_reg == ST_READ) ? rd_rho_reg : rho.idx;
    assign addr_ang  = (state_reg == ST_READ) ? rd_ang_reg : rho.angle;
    assign cell_addr = ADDR_W'(addr_idx) * ADDR_W'(NUM_ANGLES) + ADDR_W'(addr_ang);

    // Saturating increment of the counter read in the previous cycle
    assign bumped = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;

    assign ram_re    = rho.valid || (state_reg == ST_READ && rd_ok_reg);
    assign ram_we    = (state_reg == ST_CLEAR) || c_valid_reg;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : c_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : bumped;
    assign rd_count  = rd_ok_reg ? ram_rdata : '0;

    hl_acc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (cell_addr),
        .rd_data (ram_rdata)
    );

    // Output beat
    assign out_d.pad             = '0;
    assign out_d.above_threshold = m_above_reg;
    assign out_d.vote_count      = m_count_reg;
    assign m_tdata               = out_d;
    assign m_tvalid              = m_tvalid_reg;

    // Checks
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("counter RAM written while idle");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("output beat not launched from a read");

    a_vote_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VOTE && last_step) |=> (state_reg == ST_DRAIN && angle_step_reg == '0))
        else $error("angle sequencer did not wrap into drain");

    a_drain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && state_next == ST_IDLE) |-> (!rho.valid && !c_valid_reg))
        else $error("left drain with votes in flight");

endmodule
